[rtl/triangle_plane_slice_segment_macros.svh]
// Assertion macros shared by the slice segment RTL.
`ifndef TRIANGLE_PLANE_SLICE_SEGMENT_MACROS_SVH
`define TRIANGLE_PLANE_SLICE_SEGMENT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define TPSS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slice segment check failed");

// Check that cons holds a fixed number of cycles after ante.
`define TPSS_ASSERT_DELAY(label, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("slice segment latency check failed");

`endif

[rtl/tpss_pkg.sv]
// Types, constants and helpers for the triangle slice segment block.
`timescale 1ns / 1ps
package tpss_pkg;

	localparam int CW         = 32;
	localparam int DIV_STAGES = CW;
	localparam int LANES      = 4;
	localparam int LATENCY    = DIV_STAGES + 5;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [1:0] idx_t;

	typedef struct packed {
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t c_x;
		coord_t c_y;
		coord_t c_z;
	} in_t;

	typedef struct packed {
		logic   seg_valid;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} out_t;

	// One segment end: a crossing on edge h->l, or the vertex h itself.
	typedef struct packed {
		logic   vtx;
		coord_t hx;
		coord_t hy;
		coord_t hz;
		coord_t lx;
		coord_t ly;
		coord_t lz;
	} ep_t;

	typedef struct packed {
		logic          neg;
		coord_t        hc;
		logic [CW-1:0] mag;
		logic [CW-1:0] dzp;
		logic [CW-1:0] dz;
	} lane_t;

	// Sideband that travels beside the divider.
	typedef struct packed {
		logic                       have;
		logic [1:0]                 vtx;
		logic [LANES-1:0]           neg;
		logic [LANES-1:0][CW-1:0]   hc;
	} side_t;

	function automatic logic follows(idx_t p, idx_t q);
		logic r;
		case (p)
			2'd0:    r = (q == 2'd1);
			2'd1:    r = (q == 2'd2);
			2'd2:    r = (q == 2'd0);
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

[rtl/tpss_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module tpss_div_pipe import tpss_pkg::*; (
	input  logic              clk,
	input  logic [2*CW-1:0]   num,
	input  logic [CW-1:0]     den,
	output logic [CW-1:0]     quot
);

	logic [CW-1:0] rem_q [DIV_STAGES];
	logic [CW-1:0] nb_q  [DIV_STAGES];
	logic [CW-1:0] den_q [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [CW-1:0] rem_in;
		logic [CW-1:0] nb_in;
		logic [CW-1:0] den_in;
		logic [CW:0]   t;
		logic          ge;

		if (k == 0) begin : g_first
			// upper half is below den since the quotient fits in CW bits
			assign rem_in = num[2*CW-1:CW];
			assign nb_in  = num[CW-1:0];
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign nb_in  = nb_q[k-1];
			assign den_in = den_q[k-1];
		end

		assign t  = {rem_in, nb_in[CW-1]};
		assign ge = (t >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			rem_q[k] <= ge ? CW'(t - {1'b0, den_in}) : t[CW-1:0];
			nb_q[k]  <= {nb_in[CW-2:0], ge};
			den_q[k] <= den_in;
		end
	end

	assign quot = nb_q[DIV_STAGES-1];

endmodule

[rtl/triangle_plane_slice_segment.sv]
// Top level of the triangle / plane slice segment pipeline.
`timescale 1ns / 1ps
`include "triangle_plane_slice_segment_macros.svh"

// Accepts one triangle every clock cycle and returns one segment item per
// triangle, in order, on a one-cycle done strobe. Each item passes the input
// capture, vertex classing, edge difference and product register stages, the
// 32-stage divider that finishes each crossing point, and then the output
// register, five register stages around the divider in all. busy is always
// low and the receiver cannot stall, so done must be taken when it pulses.
// The plane height (plane_q) must be written through cfg_valid / cfg_ready
// only while no triangle is in flight; the block itself does not enforce it.
module triangle_plane_slice_segment import tpss_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  in_t    vertices,
	output logic   done,
	output out_t   segment,
	input  logic   cfg_valid,
	output logic   cfg_ready,
	input  coord_t cfg_data
);

	// Configuration: one register, always ready.
	coord_t plane_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			plane_q <= cfg_data;
		end
	end

	// Stage 1: capture the triangle.
	logic   vld_s1;
	in_t    vtx_s1;
	coord_t plane_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		vtx_s1   <= vertices;
		plane_s1 <= plane_q;
	end

	// Stage 1 logic: class the vertices and pick the two segment ends.
	logic have_c;
	ep_t  p_c;
	ep_t  q_c;

	always_comb begin
		coord_t vx [3];
		coord_t vy [3];
		coord_t vz [3];
		idx_t   up_i [3];
		idx_t   lo_i [3];
		idx_t   md_i [3];
		idx_t   nu;
		idx_t   nm;
		idx_t   nl;
		idx_t   m0;
		idx_t   m1;
		idx_t   lone;
		idx_t   t;
		idx_t   h0;
		idx_t   h1;
		idx_t   l0;
		idx_t   l1;
		ep_t    e;
		ep_t    v;

		vx[0] = vtx_s1.a_x; vy[0] = vtx_s1.a_y; vz[0] = vtx_s1.a_z;
		vx[1] = vtx_s1.b_x; vy[1] = vtx_s1.b_y; vz[1] = vtx_s1.b_z;
		vx[2] = vtx_s1.c_x; vy[2] = vtx_s1.c_y; vz[2] = vtx_s1.c_z;
		nu = '0; nm = '0; nl = '0;
		for (int i = 0; i < 3; i++) begin
			up_i[i] = '0; lo_i[i] = '0; md_i[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			if (vz[i] > plane_s1) begin
				up_i[nu] = idx_t'(i);
				nu       = nu + 2'd1;
			end else if (vz[i] == plane_s1) begin
				md_i[nm] = idx_t'(i);
				nm       = nm + 2'd1;
			end else begin
				lo_i[nl] = idx_t'(i);
				nl       = nl + 2'd1;
			end
		end

		have_c = 1'b0;
		p_c    = '0;
		q_c    = '0;
		m0 = '0; m1 = '0; lone = '0; t = '0;
		h0 = '0; h1 = '0; l0 = '0; l1 = '0;
		e  = '0;
		v  = '0;

		if (nm == 2'd0 && nu != 2'd0 && nl != 2'd0) begin
			// two crossing edges
			if (nu == 2'd2) begin
				m0 = up_i[0]; m1 = up_i[1]; lone = lo_i[0];
			end else begin
				m0 = lo_i[0]; m1 = lo_i[1]; lone = up_i[0];
			end
			if (!follows(m0, m1)) begin
				t = m0; m0 = m1; m1 = t;
			end
			if (nu == 2'd1) begin
				t = m0; m0 = m1; m1 = t;
			end
			if (nu == 2'd2) begin
				h0 = m1; l0 = lone; h1 = m0; l1 = lone;
			end else begin
				h0 = lone; l0 = m1; h1 = lone; l1 = m0;
			end
			p_c = '{1'b0, vx[h0], vy[h0], vz[h0], vx[l0], vy[l0], vz[l0]};
			q_c = '{1'b0, vx[h1], vy[h1], vz[h1], vx[l1], vy[l1], vz[l1]};
			have_c = 1'b1;
		end else if (nm == 2'd1 && nu == 2'd1 && nl == 2'd1) begin
			// one vertex on the plane, opposite edge crosses
			h0 = up_i[0]; l0 = lo_i[0]; m0 = md_i[0];
			e  = '{1'b0, vx[h0], vy[h0], vz[h0], vx[l0], vy[l0], vz[l0]};
			v  = '{1'b1, vx[m0], vy[m0], vz[m0], vx[m0], vy[m0], vz[m0]};
			if (follows(h0, l0)) begin
				p_c = e; q_c = v;
			end else begin
				p_c = v; q_c = e;
			end
			have_c = 1'b1;
		end else if (nm == 2'd2) begin
			// an edge lies in the plane
			m0 = md_i[0]; m1 = md_i[1];
			if (!follows(m0, m1)) begin
				t = m0; m0 = m1; m1 = t;
			end
			if (nl != 2'd0) begin
				t = m0; m0 = m1; m1 = t;
			end
			p_c = '{1'b1, vx[m0], vy[m0], vz[m0], vx[m0], vy[m0], vz[m0]};
			q_c = '{1'b1, vx[m1], vy[m1], vz[m1], vx[m1], vy[m1], vz[m1]};
			have_c = 1'b1;
		end
	end

	// Stage 2: selected ends.
	logic   vld_s2;
	logic   have_s2;
	ep_t    p_s2;
	ep_t    q_s2;
	coord_t plane_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		have_s2  <= have_c;
		p_s2     <= p_c;
		q_s2     <= q_c;
		plane_s2 <= plane_s1;
	end

	// Stage 2 logic: edge differences for each of the four lanes.
	function automatic lane_t mk_lane(coord_t hc, coord_t lc, coord_t hz, coord_t lz,
			coord_t pl);
		lane_t r;
		r.neg = (hc > lc);
		r.hc  = hc;
		r.mag = r.neg ? CW'(hc - lc) : CW'(lc - hc);
		r.dzp = CW'(hz - pl);
		r.dz  = CW'(hz - lz);
		return r;
	endfunction

	lane_t lane_c [LANES];

	assign lane_c[0] = mk_lane(p_s2.hx, p_s2.lx, p_s2.hz, p_s2.lz, plane_s2);
	assign lane_c[1] = mk_lane(p_s2.hy, p_s2.ly, p_s2.hz, p_s2.lz, plane_s2);
	assign lane_c[2] = mk_lane(q_s2.hx, q_s2.lx, q_s2.hz, q_s2.lz, plane_s2);
	assign lane_c[3] = mk_lane(q_s2.hy, q_s2.ly, q_s2.hz, q_s2.lz, plane_s2);

	// Stage 3: lane operands.
	logic       vld_s3;
	logic       have_s3;
	logic [1:0] vtx_s3;
	lane_t      lane_s3 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		have_s3 <= have_s2;
		vtx_s3  <= {q_s2.vtx, p_s2.vtx};
		for (int i = 0; i < LANES; i++) begin
			lane_s3[i] <= lane_c[i];
		end
	end

	// Stage 4: products mag * (hz - plane), divided next by hz - lz.
	logic            vld_s4;
	side_t           side_s4;
	logic [2*CW-1:0] num_s4 [LANES];
	logic [CW-1:0]   den_s4 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s4.have <= have_s3;
		side_s4.vtx  <= vtx_s3;
		for (int i = 0; i < LANES; i++) begin
			num_s4[i]         <= lane_s3[i].mag * lane_s3[i].dzp;
			den_s4[i]         <= lane_s3[i].dz;
			side_s4.neg[i]    <= lane_s3[i].neg;
			side_s4.hc[i]     <= lane_s3[i].hc;
		end
	end

	// Divider lanes; the sideband advances in step with them.
	logic [CW-1:0] quot [LANES];

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		tpss_div_pipe u_div (
			.clk  (clk),
			.num  (num_s4[g]),
			.den  (den_s4[g]),
			.quot (quot[g])
		);
	end

	logic  div_vld_q  [DIV_STAGES];
	side_t div_side_q [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				div_vld_q[k] <= 1'b0;
			end
		end else begin
			div_vld_q[0] <= vld_s4;
			for (int k = 1; k < DIV_STAGES; k++) begin
				div_vld_q[k] <= div_vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		div_side_q[0] <= side_s4;
		for (int k = 1; k < DIV_STAGES; k++) begin
			div_side_q[k] <= div_side_q[k-1];
		end
	end

	// Final logic: step from the higher endpoint, drop degenerate segments.
	side_t  side_f;
	coord_t res [LANES];
	out_t   seg_c;

	assign side_f = div_side_q[DIV_STAGES-1];

	always_comb begin
		logic vt;
		for (int i = 0; i < LANES; i++) begin
			vt = (i < 2) ? side_f.vtx[0] : side_f.vtx[1];
			if (vt) begin
				res[i] = side_f.hc[i];
			end else if (side_f.neg[i]) begin
				res[i] = side_f.hc[i] - quot[i];
			end else begin
				res[i] = side_f.hc[i] + quot[i];
			end
		end
		if (side_f.have && !(res[0] == res[2] && res[1] == res[3])) begin
			seg_c = '{1'b1, res[0], res[1], res[2], res[3]};
		end else begin
			seg_c = '0;
		end
	end

	// Output register: one-cycle strobe.
	logic done_q;
	out_t seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld_q[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		seg_q <= seg_c;
	end

	assign done    = done_q;
	assign segment = seg_q;

	`TPSS_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done)
	`TPSS_ASSERT_NOW(a_invalid_zero, done && !segment.seg_valid,
		segment.start_x == '0 && segment.start_y == '0 && segment.end_x == '0 && segment.end_y == '0)
	`TPSS_ASSERT_NOW(a_ends_differ, done && segment.seg_valid,
		segment.start_x != segment.end_x || segment.start_y != segment.end_y)

endmodule

[tb/sv/triangle_plane_slice_segment_checker.sv]
// Segment predictor and scoreboard for the triangle slice block.
`timescale 1ns / 1ps
module triangle_plane_slice_segment_checker import tpss_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  logic   busy,
	input  in_t    vertices,
	input  logic   done,
	input  out_t   segment,
	input  logic   cfg_valid,
	input  logic   cfg_ready,
	input  coord_t cfg_data,
	output int     fail_count,
	output int     pending
);

	coord_t plane_z;
	out_t   seg_q[$];

	assign pending = seg_q.size();

	// Exact crossing on edge h->l, quotient truncated toward zero.
	function automatic coord_t crossing(coord_t hc, coord_t hz, coord_t lc, coord_t lz,
			coord_t pz);
		longint signed dzp, dz, q;
		logic signed [127:0] num;
		if (hz == lz) begin
			return hc;
		end
		dzp = longint'(hz) - longint'(pz);
		dz  = longint'(hz) - longint'(lz);
		num = 128'(longint'(lc) - longint'(hc)) * 128'(dzp);
		q   = longint'(num / 128'(dz));
		return coord_t'(longint'(hc) + q);
	endfunction

	function automatic logic next_of(int p, int q);
		return q == (p + 1) % 3;
	endfunction

	function automatic out_t slice_segment(in_t v, coord_t pz);
		coord_t x[3], y[3], z[3];
		int up[3], on[3], dn[3];
		int nu, nm, nl, m0, m1, lone, t, u, l, m;
		coord_t fx, fy, tx, ty, ex, ey;
		logic got;
		out_t r;
		x = '{v.a_x, v.b_x, v.c_x};
		y = '{v.a_y, v.b_y, v.c_y};
		z = '{v.a_z, v.b_z, v.c_z};
		nu = 0; nm = 0; nl = 0; got = 0;
		fx = '0; fy = '0; tx = '0; ty = '0;
		for (int i = 0; i < 3; i++) begin
			if (z[i] > pz) up[nu++] = i;
			else if (z[i] == pz) on[nm++] = i;
			else dn[nl++] = i;
		end
		if (nm == 0 && nu >= 1 && nl >= 1) begin
			if (nu == 2) begin
				m0 = up[0]; m1 = up[1]; lone = dn[0];
			end else begin
				m0 = dn[0]; m1 = dn[1]; lone = up[0];
			end
			if (!next_of(m0, m1)) begin
				t = m0; m0 = m1; m1 = t;
			end
			if (nu == 1) begin
				t = m0; m0 = m1; m1 = t;
			end
			if (nu == 2) begin
				fx = crossing(x[m1], z[m1], x[lone], z[lone], pz);
				fy = crossing(y[m1], z[m1], y[lone], z[lone], pz);
				tx = crossing(x[m0], z[m0], x[lone], z[lone], pz);
				ty = crossing(y[m0], z[m0], y[lone], z[lone], pz);
			end else begin
				fx = crossing(x[lone], z[lone], x[m1], z[m1], pz);
				fy = crossing(y[lone], z[lone], y[m1], z[m1], pz);
				tx = crossing(x[lone], z[lone], x[m0], z[m0], pz);
				ty = crossing(y[lone], z[lone], y[m0], z[m0], pz);
			end
			got = 1;
		end else if (nm == 1 && nu == 1 && nl == 1) begin
			u = up[0]; l = dn[0]; m = on[0];
			ex = crossing(x[u], z[u], x[l], z[l], pz);
			ey = crossing(y[u], z[u], y[l], z[l], pz);
			if (next_of(u, l)) begin
				fx = ex; fy = ey; tx = x[m]; ty = y[m];
			end else begin
				fx = x[m]; fy = y[m]; tx = ex; ty = ey;
			end
			got = 1;
		end else if (nm == 2) begin
			m0 = on[0]; m1 = on[1];
			if (!next_of(m0, m1)) begin
				t = m0; m0 = m1; m1 = t;
			end
			if (nl != 0) begin
				t = m0; m0 = m1; m1 = t;
			end
			fx = x[m0]; fy = y[m0]; tx = x[m1]; ty = y[m1];
			got = 1;
		end
		r = '0;
		if (got && !(fx == tx && fy == ty)) begin
			r.seg_valid = 1'b1;
			r.start_x = fx; r.start_y = fy; r.end_x = tx; r.end_y = ty;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			plane_z    <= '0;
			fail_count <= 0;
			seg_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) plane_z <= cfg_data;
			if (start && !busy) seg_q.insert(seg_q.size(), slice_segment(vertices, plane_z));
			if (done) begin
				if (seg_q.size() == 0) begin
					$display("%0t: segment with nothing expected, actual %h", $time, segment);
					fail_count <= fail_count + 1;
				end else begin
					want = seg_q[0];
					seg_q.delete(0);
					if (want !== segment) begin
						$display("%0t: segment mismatch expected %h actual %h",
							$time, want, segment);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

[tb/sv/triangle_plane_slice_segment_tb.sv]
// Stimulus and verdict for the triangle slice segment testbench.
`timescale 1ns / 1ps
module triangle_plane_slice_segment_tb;
	import tpss_pkg::*;

	localparam int WATCHDOG = 20000;

	logic   clk = 0;
	logic   arst_n = 0;
	logic   start = 0;
	logic   busy;
	in_t    vertices = '0;
	logic   done;
	out_t   segment;
	logic   cfg_valid = 0;
	logic   cfg_ready;
	coord_t cfg_data = '0;
	int     fail_count, pending;
	int     quiet_cycles = 0;
	coord_t plane_now = '0;
	logic   calm = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	triangle_plane_slice_segment u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .vertices(vertices),
		.done(done), .segment(segment), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	triangle_plane_slice_segment_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .vertices(vertices),
		.done(done), .segment(segment), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
	);

	// Count cycles with no accepted item on any channel; give up past the limit.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Hold one triangle on the port until it is taken, idling at random first.
	// start stays high after the item is taken so items can follow back to back.
	task automatic send_triangle(in_t v);
		if (!calm) begin
			while ($urandom_range(99) < 34) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		start    <= 1'b1;
		vertices <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// Drain the pipeline, let trailing cycles pass, then write the plane height.
	task automatic set_plane(coord_t h);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= h;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		plane_now = h;
	endtask

	function automatic coord_t rnd_coord();
		case ($urandom_range(5))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return coord_t'($urandom_range(200)) - 100;
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Pick z relative to the plane: above, on or below, with a random spread.
	function automatic coord_t rnd_z(int side);
		longint d;
		d = ($urandom_range(3) == 0) ? longint'($urandom) : longint'($urandom_range(1 << 20));
		if (d == 0) d = 1;
		if (side == 0) return plane_now;
		if (side > 0) return (longint'(plane_now) + d > 64'sh7fff_ffff) ?
			coord_t'(32'sh7fff_ffff) : coord_t'(longint'(plane_now) + d);
		return (longint'(plane_now) - d < -64'sh8000_0000) ?
			coord_t'(32'sh8000_0000) : coord_t'(longint'(plane_now) - d);
	endfunction

	function automatic in_t rnd_triangle();
		in_t v;
		int sa, sb, sc;
		v = '0;
		sa = int'($urandom_range(2)) - 1;
		sb = int'($urandom_range(2)) - 1;
		sc = int'($urandom_range(2)) - 1;
		v.a_x = rnd_coord(); v.a_y = rnd_coord();
		v.b_x = rnd_coord(); v.b_y = rnd_coord();
		v.c_x = rnd_coord(); v.c_y = rnd_coord();
		// Now and then repeat a vertex so that ends coincide.
		if ($urandom_range(15) == 0) begin
			v.b_x = v.a_x; v.b_y = v.a_y;
		end
		if ($urandom_range(9) == 0) begin
			v.a_z = coord_t'($urandom); v.b_z = coord_t'($urandom); v.c_z = coord_t'($urandom);
		end else begin
			v.a_z = rnd_z(sa); v.b_z = rnd_z(sb); v.c_z = rnd_z(sc);
		end
		return v;
	endfunction

	function automatic in_t tri_z(coord_t za, coord_t zb, coord_t zc);
		in_t v;
		v = '{a_x: 32'sh0001_0000, a_y: -32'sh0002_0000, a_z: za,
			b_x: 32'sh7fff_ffff, b_y: 32'sh0003_0000, b_z: zb,
			c_x: 32'sh8000_0000, c_y: 32'sh7fff_ffff, c_z: zc};
		return v;
	endfunction

	initial begin
		in_t v;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: every class of vertex pattern at plane zero.
		send_triangle(tri_z(10, 20, -5));
		send_triangle(tri_z(-10, 20, 5));
		send_triangle(tri_z(10, -20, -5));
		send_triangle(tri_z(-10, -20, 5));
		send_triangle(tri_z(0, 20, -5));
		send_triangle(tri_z(0, -20, 5));
		send_triangle(tri_z(0, 0, 5));
		send_triangle(tri_z(0, 0, -5));
		send_triangle(tri_z(0, 0, 0));
		send_triangle(tri_z(1, 2, 3));
		send_triangle(tri_z(-1, -2, -3));
		send_triangle(tri_z(0, 2, 3));
		send_triangle(tri_z(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000));
		send_triangle(tri_z(32'sh8000_0000, 32'sh7fff_ffff, 0));
		v = tri_z(0, 0, 7);
		v.b_x = v.a_x; v.b_y = v.a_y;
		send_triangle(v);
		send_triangle('1);
		send_triangle('0);

		// Plane at the extremes, then random heights.
		set_plane(32'sh7fff_ffff);
		send_triangle(tri_z(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff));
		send_triangle(tri_z(32'sh7fff_ffff, 32'sh7fff_fffe, 5));
		set_plane(32'sh8000_0000);
		send_triangle(tri_z(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000));
		send_triangle(tri_z(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0001));

		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 4) set_plane(32'sh7fff_f000);
			else if (phase == 5) set_plane(-32'sh7fff_f000);
			else set_plane(phase == 0 ? coord_t'(0) : coord_t'($urandom));
			calm = (phase == 2);
			for (int k = 0; k < 90; k++) send_triangle(rnd_triangle());
		end
		calm = 0;
		start <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		if (fail_count == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule
